/* rtl/core/iidt_pkg.sv */
// Shared types, codes and defaults for the interface identifier table.
package iidt_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int ID_BITS_DEF = 16;
  localparam int FIRST_ID    = 1;
  localparam int MAC_W       = 48;
  localparam int MTU_W       = 16;
  localparam int TID_W       = 16;

  typedef logic [1:0] req_code_t;
  typedef logic [1:0] status_t;

  localparam req_code_t REQ_CREATE = 2'd0;
  localparam req_code_t REQ_DELETE = 2'd1;
  localparam req_code_t REQ_ADMIN  = 2'd2;
  localparam req_code_t REQ_GET    = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOSPACE  = 2'd1;
  localparam status_t ST_INVAL    = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  typedef struct packed {
    req_code_t         req_type;
    logic [TID_W-1:0]  target_id;
    logic              mac_present;
    logic [MAC_W-1:0]  mac_addr;
    logic [MTU_W-1:0]  mtu_value;
    logic              admin_flag;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [TID_W-1:0]  result_id;
    logic [MAC_W-1:0]  mac_out;
    logic [MTU_W-1:0]  mtu_out;
    logic              admin_out;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    cap;
    logic    step;
    logic    create;
    logic    look;
    logic    hit;
    logic    err;
    status_t err_code;
    logic    load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_create;
    logic is_delete;
    logic id_zero;
    logic slot_free;
    logic idx_last;
    logic hit;
    logic pend_last;
    logic out_busy;
  } stat_t;

endpackage

/* rtl/core/iidt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module iidt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                            clk,
  input  logic                                            we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
  input  logic [WIDTH-1:0]                                wdata,
  input  logic                                            re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
  output logic [WIDTH-1:0]                                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/iidt_ctrl.sv */
// Request sequencing state machine for the interface identifier table.
module iidt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  iidt_pkg::stat_t stat,
  output iidt_pkg::cmd_t  cmd
);
  import iidt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_FREE = 3'd2;
  localparam logic [2:0] S_LOOK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.is_create) begin
          state_next = S_FREE;
        end else if (stat.id_zero) begin
          // Zero never matches; only delete reports it as invalid.
          cmd.err      = 1'b1;
          cmd.err_code = stat.is_delete ? ST_INVAL : ST_NOTFOUND;
          state_next   = S_DONE;
        end else begin
          state_next = S_LOOK;
        end
      end
      S_FREE: begin
        if (stat.slot_free) begin
          cmd.create = 1'b1;
          state_next = S_DONE;
        end else if (stat.idx_last) begin
          cmd.err      = 1'b1;
          cmd.err_code = ST_NOSPACE;
          state_next   = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_LOOK: begin
        if (stat.hit) begin
          cmd.hit    = 1'b1;
          state_next = S_DONE;
        end else if (stat.pend_last) begin
          cmd.err      = 1'b1;
          cmd.err_code = ST_NOTFOUND;
          state_next   = S_DONE;
        end else begin
          cmd.look = 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/iidt_dp.sv */
// Datapath: slot storage, scan index, identifier counter and result registers.
module iidt_dp #(
  parameter int ENTRIES = iidt_pkg::ENTRIES_DEF,
  parameter int ID_BITS = iidt_pkg::ID_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  iidt_pkg::req_t  req_data,
  input  iidt_pkg::cmd_t  cmd,
  output iidt_pkg::stat_t stat,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output iidt_pkg::rsp_t  rsp_data
);
  import iidt_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WORD_W = ID_BITS + MAC_W + MTU_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  req_t               rq;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   rd_idx;
  logic               pend;
  logic               pend_on;
  logic [ENTRIES-1:0] slot_used;
  logic [ID_BITS-1:0] next_id;
  logic [ID_BITS-1:0] id_inc;
  logic [ID_BITS-1:0] tid_k;
  rsp_t               res;
  rsp_t               res_next;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WORD_W-1:0]  ram_q;
  logic [ID_BITS-1:0] q_id;
  logic [MAC_W-1:0]   q_mac;
  logic [MTU_W-1:0]   q_mtu;
  logic               q_admin;
  logic [MAC_W-1:0]   new_mac;

  // Slot word: identifier, MAC, MTU, admin flag (low bit).
  assign q_admin = ram_q[0];
  assign q_mtu   = ram_q[1 +: MTU_W];
  assign q_mac   = ram_q[1 + MTU_W +: MAC_W];
  assign q_id    = ram_q[WORD_W-1 -: ID_BITS];

  assign tid_k   = ID_BITS'(rq.target_id);
  assign new_mac = rq.mac_present ? rq.mac_addr : '0;
  assign id_inc  = next_id + ID_BITS'(1);

  assign stat.is_create = (rq.req_type == REQ_CREATE);
  assign stat.is_delete = (rq.req_type == REQ_DELETE);
  assign stat.id_zero   = (tid_k == '0);
  assign stat.slot_free = !slot_used[idx];
  assign stat.idx_last  = (idx == LAST_IDX);
  assign stat.hit       = pend && pend_on && (q_id == tid_k);
  assign stat.pend_last = pend && (rd_idx == LAST_IDX);
  assign stat.out_busy  = rsp_valid && !rsp_ready;

  assign ram_we    = cmd.create || (cmd.hit && rq.req_type == REQ_ADMIN);
  assign ram_waddr = cmd.create ? idx : rd_idx;
  assign ram_wdata = cmd.create ? {next_id, new_mac, rq.mtu_value, 1'b0}
                                : {q_id, q_mac, q_mtu, rq.admin_flag};

  iidt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.look),
    .raddr (idx),
    .rdata (ram_q)
  );

  always_comb begin
    res_next = '0;
    if (cmd.err) begin
      res_next.status = cmd.err_code;
    end else if (cmd.create) begin
      res_next.status    = ST_OK;
      res_next.result_id = TID_W'(next_id);
    end else if (rq.req_type == REQ_GET) begin
      res_next.status    = ST_OK;
      res_next.result_id = TID_W'(q_id);
      res_next.mac_out   = q_mac;
      res_next.mtu_out   = q_mtu;
      res_next.admin_out = q_admin;
    end else begin
      res_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      next_id   <= ID_BITS'(FIRST_ID);
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.cap) begin
        pend <= 1'b0;
      end else if (cmd.look) begin
        pend <= 1'b1;
      end
      if (cmd.create) begin
        slot_used[idx] <= 1'b1;
        // The counter skips zero when it wraps.
        next_id <= (id_inc == '0) ? ID_BITS'(FIRST_ID) : id_inc;
      end
      if (cmd.hit && rq.req_type == REQ_DELETE) begin
        slot_used[rd_idx] <= 1'b0;
      end
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      rq  <= req_data;
      idx <= '0;
    end else if (cmd.step || (cmd.look && idx != LAST_IDX)) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.look) begin
      rd_idx  <= idx;
      pend_on <= slot_used[idx];
    end
    if (cmd.err || cmd.create || cmd.hit) begin
      res <= res_next;
    end
    if (cmd.load) begin
      rsp_data <= res;
    end
  end

endmodule

/* rtl/core/interface_id_table_core.sv */
// Interface identifier table top level: controller plus datapath.
// Each request gives exactly one response. A create scans the slot-used bits one per cycle
// for the lowest free slot; delete, set-admin and get scan the slot RAM one entry per cycle
// through its registered read port and stop at the lowest slot holding the identifier. A
// new request is taken once the previous response has moved into the output register.
// Reset frees every slot at once through per-slot used bits; no clearing pass is needed.
module interface_id_table_core #(
  parameter int ENTRIES = iidt_pkg::ENTRIES_DEF,
  parameter int ID_BITS = iidt_pkg::ID_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  iidt_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output iidt_pkg::rsp_t rsp_data
);
  import iidt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  iidt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  iidt_dp #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  a_create_free: assert property (@(posedge clk) disable iff (rst)
    cmd.create |-> stat.slot_free)
    else $error("create issued on an occupied slot");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken while one is in progress");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> rsp_valid)
    else $error("response loaded but not presented");

  a_hit_not_create: assert property (@(posedge clk) disable iff (rst)
    cmd.hit |-> !stat.is_create)
    else $error("lookup hit during a create");

endmodule

/* tb/iidt_tb_pkg.sv */
// Shadow interface table and response scoreboard for the identifier table testbench.
package iidt_tb_pkg;
  import iidt_pkg::*;

  class iface_table_tracker;
    logic [TID_W-1:0] shadow_id    [ENTRIES_DEF];
    logic [MAC_W-1:0] shadow_mac   [ENTRIES_DEF];
    logic [MTU_W-1:0] shadow_mtu   [ENTRIES_DEF];
    logic             shadow_admin [ENTRIES_DEF];
    int               used_count;
    logic [TID_W-1:0] next_id;
    rsp_t             pending_rsp[$];
    int               mismatch_count;

    function new();
      foreach (shadow_id[i]) begin
        shadow_id[i]    = '0;
        shadow_mac[i]   = '0;
        shadow_mtu[i]   = '0;
        shadow_admin[i] = 1'b0;
      end
      used_count     = 0;
      next_id        = FIRST_ID;
      mismatch_count = 0;
    endfunction

    // Lowest slot holding the identifier; zero never matches since free slots hold zero.
    function int lookup_slot(logic [TID_W-1:0] id);
      if (id == '0) return -1;
      foreach (shadow_id[i]) begin
        if (shadow_id[i] == id) return i;
      end
      return -1;
    endfunction

    function logic [TID_W-1:0] pick_live_id();
      logic [TID_W-1:0] live[$];
      foreach (shadow_id[i]) begin
        if (shadow_id[i] != '0) live.push_back(shadow_id[i]);
      end
      if (live.size() == 0) return '0;
      return live[$urandom_range(live.size() - 1)];
    endfunction

    // Applies an accepted request to the shadow table and queues the response it must give.
    function void apply_request(req_t r);
      rsp_t want;
      int   s;
      want = '0;
      want.status = ST_OK;
      s = -1;
      case (r.req_type)
        REQ_CREATE: begin
          if (used_count < ENTRIES_DEF) begin
            foreach (shadow_id[i]) begin
              if (s < 0 && shadow_id[i] == '0) s = i;
            end
          end
          if (s < 0) begin
            want.status = ST_NOSPACE;
          end else begin
            shadow_id[s]    = next_id;
            shadow_mac[s]   = r.mac_present ? r.mac_addr : '0;
            shadow_mtu[s]   = r.mtu_value;
            shadow_admin[s] = 1'b0;
            used_count++;
            want.result_id  = next_id;
            next_id         = next_id + 1'b1;
            if (next_id == '0) next_id = FIRST_ID;
          end
        end
        REQ_DELETE: begin
          if (r.target_id == '0) begin
            want.status = ST_INVAL;
          end else begin
            s = lookup_slot(r.target_id);
            if (s < 0) begin
              want.status = ST_NOTFOUND;
            end else begin
              shadow_id[s] = '0;
              used_count--;
            end
          end
        end
        REQ_ADMIN: begin
          s = lookup_slot(r.target_id);
          if (s < 0) want.status = ST_NOTFOUND;
          else shadow_admin[s] = r.admin_flag;
        end
        REQ_GET: begin
          s = lookup_slot(r.target_id);
          if (s < 0) begin
            want.status = ST_NOTFOUND;
          end else begin
            want.result_id = shadow_id[s];
            want.mac_out   = shadow_mac[s];
            want.mtu_out   = shadow_mtu[s];
            want.admin_out = shadow_admin[s];
          end
        end
      endcase
      pending_rsp.push_back(want);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected response: st=%0d id=%h mac=%h mtu=%h adm=%b",
                   got.status, got.result_id, got.mac_out, got.mtu_out, got.admin_out);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status || got.result_id !== want.result_id ||
          got.mac_out !== want.mac_out || got.mtu_out !== want.mtu_out ||
          got.admin_out !== want.admin_out) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("response mismatch: expected st=%0d id=%h mac=%h mtu=%h adm=%b, %s",
                   want.status, want.result_id, want.mac_out, want.mtu_out, want.admin_out,
                   $sformatf("got st=%0d id=%h mac=%h mtu=%h adm=%b", got.status,
                             got.result_id, got.mac_out, got.mtu_out, got.admin_out));
      end
    endfunction
  endclass

endpackage

/* tb/tb_interface_id_table_core.sv */
// Testbench top for the interface identifier table core.
module tb_interface_id_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import iidt_pkg::*;
  import iidt_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req_data;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp_data;

  int   send_idle_pct;
  int   stall_pct;
  logic hold_rsp;
  int   quiet_cycles;

  iface_table_tracker table_sb = new();

  interface_id_table_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) table_sb.apply_request(req_data);
    if (!rst && rsp_valid && rsp_ready) table_sb.check_response(rsp_data);
  end

  // Response side: random stalls, plus one long hold-off on request from the main sequence.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic issue(input req_code_t kind, input logic [TID_W-1:0] tid,
                       input logic mac_on, input logic [MAC_W-1:0] mac,
                       input logic [MTU_W-1:0] mtu, input logic admin_on);
    req_t r;
    r.req_type    = kind;
    r.target_id   = tid;
    r.mac_present = mac_on;
    r.mac_addr    = mac;
    r.mtu_value   = mtu;
    r.admin_flag  = admin_on;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic create_random();
    logic [63:0] w;
    w = {$urandom, $urandom};
    issue(REQ_CREATE, w[15:0], w[63], w[47:0], w[62:47], w[16]);
  endtask

  task automatic issue_random();
    int               roll;
    req_code_t        kind;
    logic [TID_W-1:0] tid;
    logic [63:0]      w1;
    logic [63:0]      w2;
    w1 = {$urandom, $urandom};
    w2 = {$urandom, $urandom};
    roll = $urandom_range(99);
    if (roll < 30)      kind = REQ_CREATE;
    else if (roll < 55) kind = REQ_DELETE;
    else if (roll < 75) kind = REQ_ADMIN;
    else                kind = REQ_GET;
    // Mostly live identifiers so that requests find entries; the rest probe misses.
    roll = $urandom_range(99);
    if (roll < 70)      tid = table_sb.pick_live_id();
    else if (roll < 80) tid = '0;
    else if (roll < 90) tid = table_sb.next_id;
    else                tid = w2[15:0];
    issue(kind, tid, w2[16], w1[47:0], w1[63:48], w2[17]);
  endtask

  task automatic run_phase(input int send_pct, input int stall);
    send_idle_pct = send_pct;
    stall_pct     = stall;
    repeat (100) issue_random();
  endtask

  initial begin
    rst           = 1'b1;
    req_valid     = 1'b0;
    req_data      = '0;
    hold_rsp      = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty table: identifier zero and unknown identifiers.
    issue(REQ_GET,    '0,       1'b0, '0, '0, 1'b0);
    issue(REQ_DELETE, '0,       1'b0, '0, '0, 1'b0);
    issue(REQ_ADMIN,  '0,       1'b0, '0, '0, 1'b1);
    issue(REQ_DELETE, 16'h1234, 1'b0, '0, '0, 1'b0);
    // Field extremes, and a create without a MAC that must store zeros.
    issue(REQ_CREATE, 16'hFFFF, 1'b1, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
    issue(REQ_CREATE, 16'h0000, 1'b0, 48'hA5A5_5A5A_C3C3, 16'h0000, 1'b1);
    issue(REQ_ADMIN,  16'd1,    1'b0, '0, '0, 1'b1);
    issue(REQ_ADMIN,  16'hFFFF, 1'b0, '0, '0, 1'b1);
    issue(REQ_GET,    16'd1,    1'b0, '0, '0, 1'b0);
    issue(REQ_GET,    16'd2,    1'b0, '0, '0, 1'b0);
    issue(REQ_GET,    16'hFFFF, 1'b0, '0, '0, 1'b0);
    issue(REQ_DELETE, 16'd2,    1'b0, '0, '0, 1'b0);
    issue(REQ_GET,    16'd2,    1'b0, '0, '0, 1'b0);

    // Fill the table, hit the full case, then reuse a hole in the middle.
    while (table_sb.used_count < ENTRIES_DEF) create_random();
    create_random();
    issue(REQ_DELETE, table_sb.shadow_id[6], 1'b0, '0, '0, 1'b0);
    create_random();
    for (int s = 1; s < ENTRIES_DEF; s++) begin
      if (table_sb.shadow_id[s] != '0)
        issue(REQ_DELETE, table_sb.shadow_id[s], 1'b0, '0, '0, 1'b0);
    end

    // Identifier 1 still sits in slot 0; update it, delete it, then look for it again.
    create_random();
    issue(REQ_GET,    16'd1, 1'b0, '0, '0, 1'b0);
    issue(REQ_ADMIN,  16'd1, 1'b0, '0, '0, 1'b0);
    issue(REQ_GET,    16'd1, 1'b0, '0, '0, 1'b0);
    issue(REQ_DELETE, 16'd1, 1'b0, '0, '0, 1'b0);
    issue(REQ_GET,    16'd1, 1'b0, '0, '0, 1'b0);
    issue(REQ_DELETE, 16'd1, 1'b0, '0, '0, 1'b0);
    issue(REQ_GET,    16'd1, 1'b0, '0, '0, 1'b0);

    // The response side holds off at the start of the first phase so the block backs up.
    hold_rsp = 1'b1;
    run_phase(0, 0);
    run_phase(55, 0);
    run_phase(0, 55);
    run_phase(18, 18);
    req_valid <= 1'b0;

    while (table_sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (ENTRIES_DEF + 8) @(posedge clk);
    if (table_sb.mismatch_count == 0 && table_sb.pending_rsp.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
